/* hdl/rsdam_pkg.sv */
// Shared constants and types for the streaming small-regex matcher.
// No dependencies; used by regex_star_dot_anchor_match.
package rsdam_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int POS_W       = $clog2(PATTERN_MAX + 1);
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // one bit for each pattern position, plus the "whole pattern consumed" position
    typedef logic [PATTERN_MAX:0]   t_posvec;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [7:0]             t_byte;

    typedef enum logic [1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_idx;

endpackage

/* hdl/regex_star_dot_anchor_match.sv */
// Streaming small-regex matcher: literals, '.', 'c*', leading '^', trailing '$'.
// Depends on rsdam_pkg for pattern size, special characters and register indexes.
//
//   channel  dir  handshake               payload
//   input    in   i_valid / o_ready       i_text_byte, i_end_of_text
//   result   out  o_valid / i_ready       o_matched (one per terminator item)
//   config   in   i_cfg_wr_en             i_cfg_index, i_cfg_data
//
// One item per cycle sustained unless a terminator waits on a full result register: an
// accepted item lands in the input register, and from there the position-vector update
// (star closure and byte compare) runs into the state and result registers. Results
// pass the input register, then the result register. Reset is synchronous and active low.
// Only a terminator item waits on a full result register; text bytes never stall.
module regex_star_dot_anchor_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_matched,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [rsdam_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int N = rsdam_pkg::PATTERN_MAX;

    // configuration
    logic [rsdam_pkg::CFG_DATA_W-1:0] r_pat_low;
    logic [rsdam_pkg::CFG_DATA_W-1:0] r_pat_high;
    logic [rsdam_pkg::LEN_W-1:0]      r_pat_len;

    // input register
    logic                  r_in_valid;
    rsdam_pkg::t_byte      r_in_byte;
    logic                  r_in_eot;

    // matcher state
    rsdam_pkg::t_posvec    r_live;
    logic                  r_seen;
    logic                  r_at_start;

    // result register
    logic                  r_out_valid;
    logic                  r_matched;

    // pattern decode
    rsdam_pkg::t_byte [N-1:0] pat;
    rsdam_pkg::t_pos          n;
    logic [N-1:0]             lt_n;
    logic [N-1:0]             star;
    logic [N-1:0]             dollar;
    logic                     anchored;

    // per-item datapath
    rsdam_pkg::t_posvec    cur;
    rsdam_pkg::t_posvec    n_live;
    logic                  hit;
    logic                  end_hit;
    logic                  process;

    always_comb begin
        logic [rsdam_pkg::LEN_W-1:0] len_sat;
        for (int i = 0; i < N; i++) begin
            if (i < 8) begin
                pat[i] = r_pat_low[8*i +: 8];
            end else begin
                pat[i] = r_pat_high[8*(i-8) +: 8];
            end
        end
        if (r_pat_len > rsdam_pkg::LEN_W'(N)) begin
            len_sat = rsdam_pkg::LEN_W'(N);
        end else begin
            len_sat = r_pat_len;
        end
        // the pattern stops at the first zero byte inside the length
        n = rsdam_pkg::POS_W'(len_sat);
        for (int i = N - 1; i >= 0; i--) begin
            if (rsdam_pkg::LEN_W'(i) < len_sat && pat[i] == 8'h00) begin
                n = rsdam_pkg::POS_W'(i);
            end
        end
        for (int i = 0; i < N; i++) begin
            lt_n[i]   = rsdam_pkg::POS_W'(i) < n;
            dollar[i] = (rsdam_pkg::POS_W'(i + 1) == n) && (pat[i] == rsdam_pkg::CH_DOLLAR);
            if (i < N - 1) begin
                star[i] = (rsdam_pkg::POS_W'(i + 1) < n) && (pat[i+1] == rsdam_pkg::CH_STAR);
            end else begin
                star[i] = 1'b0;
            end
        end
        anchored = (n != '0) && (pat[0] == rsdam_pkg::CH_CARET);
    end

    always_comb begin
        rsdam_pkg::t_posvec live_in;
        for (int i = 0; i <= N; i++) begin
            live_in[i] = r_live[i] & (rsdam_pkg::POS_W'(i) <= n);
        end
        cur = live_in;
        // seed the start position: once for an anchored pattern, on every byte otherwise
        if (!anchored) begin
            cur[0] = 1'b1;
        end else if (r_at_start) begin
            cur[1] = 1'b1;
        end
        // positions only move forward, so one ascending pass closes over stars
        for (int i = 0; i < N - 1; i++) begin
            if (cur[i] && star[i]) begin
                cur[i+2] = 1'b1;
            end
        end
        hit     = cur[n];
        end_hit = |(cur[N-1:0] & dollar);

        n_live = '0;
        for (int i = 0; i < N; i++) begin
            if (cur[i] && lt_n[i] && !dollar[i]
                    && (pat[i] == rsdam_pkg::CH_DOT || pat[i] == r_in_byte)) begin
                if (star[i]) begin
                    n_live[i] = 1'b1;
                end else begin
                    n_live[i+1] = 1'b1;
                end
            end
        end
    end

    // a terminator needs a free result register; text bytes always go through
    assign process = r_in_valid && (!r_in_eot || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rsdam_pkg::CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                rsdam_pkg::CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                rsdam_pkg::CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[rsdam_pkg::LEN_W-1:0];
                default: begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_seen     <= 1'b0;
            r_at_start <= 1'b1;
        end else if (process) begin
            if (r_in_eot) begin
                r_live     <= '0;
                r_seen     <= 1'b0;
                r_at_start <= 1'b1;
            end else begin
                r_live     <= n_live;
                r_seen     <= r_seen | hit;
                r_at_start <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && r_in_eot) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && r_in_eot) begin
            r_matched <= r_seen | hit | end_hit;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_matched;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for regex_star_dot_anchor_match: directed rows, then random texts.
// Depends on rsdam_pkg and the matcher RTL; results are checked against directed expectations or a local predictor.
module testbench;

    localparam int LIMIT        = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE       = 4;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [7:0]  i_text_byte   = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic        o_matched;
    logic        i_cfg_wr_en   = 1'b0;
    rsdam_pkg::t_cfg_idx cfg_idx = rsdam_pkg::CFG_PAT_LOW;
    logic [rsdam_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    regex_star_dot_anchor_match u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_matched     (o_matched),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor copy of registers and matcher state
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len = '0;
    rsdam_pkg::t_posvec live_pos = '0;
    bit          match_found = 1'b0;
    bit          text_start = 1'b1;

    logic        verdicts_due[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        want;

    typedef struct {
        bit    load;
        string pat;
        int    plen;
        string txt;   // '#' stands for a zero byte
        bit    term;
        int    want;  // -1: predictor only
    } t_case;

    t_case cases[25] = '{
        '{1'b0, "",                 0,  "",                 1'b1,  1},
        '{1'b1, "abc",              3,  "xxabcyy",          1'b1,  1},
        '{1'b1, "abc",              3,  "ababd",            1'b1,  0},
        '{1'b1, "^ab",              3,  "abx",              1'b1,  1},
        '{1'b1, "^ab",              3,  "xab",              1'b1,  0},
        '{1'b1, "ab$",              3,  "xxab",             1'b1,  1},
        '{1'b1, "ab$",              3,  "abx",              1'b1,  0},
        '{1'b1, "^a*$",             4,  "",                 1'b1,  1},
        '{1'b1, "^a*$",             4,  "aaaa",             1'b1,  1},
        '{1'b1, "^a*$",             4,  "aaba",             1'b1,  0},
        '{1'b1, "a.c",              3,  "a#c",              1'b1,  1},
        '{1'b1, "a",                1,  "#",                1'b1,  0},
        '{1'b1, ".*",               2,  "\377",             1'b1,  1},
        '{1'b1, "x^y",              3,  "x^y",              1'b1,  1},
        '{1'b1, "$a",               2,  "$a",               1'b1,  1},
        '{1'b1, "*a",               2,  "*a",               1'b1,  1},
        '{1'b1, "ab",               4,  "xab",              1'b1,  1},
        '{1'b1, "abcdefghijklmnop", 31, "abcdefghijklmnop", 1'b1,  1},
        '{1'b1, "abcdefghijklmnop", 16, "abcdefghijklmno",  1'b1,  0},
        '{1'b1, "",                 0,  "anything",         1'b1,  1},
        '{1'b1, "^$",               2,  "",                 1'b1,  1},
        // pattern swapped mid-text: live positions carry over
        '{1'b1, "abcd",             4,  "ab",               1'b0, -1},
        '{1'b1, "abxy",             4,  "xy",               1'b1, -1},
        '{1'b1, "abcdef",           6,  "abcd",             1'b0, -1},
        '{1'b1, "ab",               2,  "",                 1'b1, -1}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with none expected: expected none, actual %0b",
                         $time, o_matched);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_matched !== want) begin
                    $display("%0t: matched mismatch: expected %0b, actual %0b",
                             $time, want, o_matched);
                    mismatches++;
                end
            end
        end
    end

    function automatic rsdam_pkg::t_byte pat_at(int i);
        if (i < 8)
            return pat_lo[8*i +: 8];
        if (i < 16)
            return pat_hi[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    function automatic int used_len();
        int n;
        n = (pat_len > rsdam_pkg::PATTERN_MAX) ? rsdam_pkg::PATTERN_MAX : int'(pat_len);
        for (int i = 0; i < n; i++)
            if (pat_at(i) == 8'h00)
                return i;
        return n;
    endfunction

    function automatic bit star_after(int i, int n);
        return (i + 1 < n) && (pat_at(i + 1) == rsdam_pkg::CH_STAR);
    endfunction

    function automatic bit end_anchor(int i, int n);
        return (i + 1 == n) && (pat_at(i) == rsdam_pkg::CH_DOLLAR);
    endfunction

    // Returns 1 when the item yields a result; verdict carries it.
    function automatic bit advance_matcher(input rsdam_pkg::t_byte b, input logic eot,
                                           output logic verdict);
        int                 n;
        int                 start;
        bit                 anchored;
        bit                 hit;
        rsdam_pkg::t_posvec cur;
        rsdam_pkg::t_posvec nxt;
        rsdam_pkg::t_posvec mask;
        rsdam_pkg::t_byte   c;
        n        = used_len();
        anchored = (n >= 1) && (pat_at(0) == rsdam_pkg::CH_CARET);
        start    = anchored ? 1 : 0;
        verdict  = 1'b0;
        mask     = '0;
        for (int i = 0; i <= n; i++)
            mask[i] = 1'b1;
        cur = live_pos & mask;
        if (!anchored || text_start)
            cur[start] = 1'b1;
        // positions only move forward, so one ascending pass closes over stars
        for (int i = 0; i < n; i++)
            if (cur[i] && star_after(i, n))
                cur[i+2] = 1'b1;
        hit = cur[n];
        if (eot) begin
            if (n >= 1 && cur[n-1] && end_anchor(n - 1, n))
                hit = 1'b1;
            verdict     = match_found | hit;
            live_pos    = '0;
            match_found = 1'b0;
            text_start  = 1'b1;
            return 1'b1;
        end
        if (hit)
            match_found = 1'b1;
        nxt = '0;
        for (int i = 0; i < n; i++) begin
            if (cur[i]) begin
                c = pat_at(i);
                if (star_after(i, n)) begin
                    if (c == rsdam_pkg::CH_DOT || c == b)
                        nxt[i] = 1'b1;
                end else if (!end_anchor(i, n) && (c == rsdam_pkg::CH_DOT || c == b)) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        live_pos   = nxt;
        text_start = 1'b0;
        return 1'b0;
    endfunction

    task automatic push_item(input rsdam_pkg::t_byte b, input logic eot, input int typed);
        logic verdict;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (advance_matcher(b, eot, verdict))
            verdicts_due.push_back((typed >= 0) ? typed[0] : verdict);
    endtask

    // Drop valid, then hold off until every result is back and the pipeline has emptied.
    task automatic drain();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len);
        logic [63:0] junk;
        junk        = {$urandom, $urandom};
        i_cfg_wr_en <= 1'b1;
        cfg_idx     <= rsdam_pkg::CFG_PAT_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        cfg_idx     <= rsdam_pkg::CFG_PAT_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        // upper data bits are don't-care for the length register
        cfg_idx     <= rsdam_pkg::CFG_PAT_LEN;
        i_cfg_data  <= {junk[63:5], len};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        pat_lo  = lo;
        pat_hi  = hi;
        pat_len = len;
    endtask

    function automatic rsdam_pkg::t_byte pattern_symbol();
        int r;
        r = $urandom_range(99);
        if (r < 50) return rsdam_pkg::t_byte'(8'h61 + $urandom_range(2));
        if (r < 62) return rsdam_pkg::CH_DOT;
        if (r < 78) return rsdam_pkg::CH_STAR;
        if (r < 84) return rsdam_pkg::CH_CARET;
        if (r < 90) return rsdam_pkg::CH_DOLLAR;
        if (r < 93) return 8'h00;
        return rsdam_pkg::t_byte'($urandom);
    endfunction

    function automatic rsdam_pkg::t_byte text_symbol();
        int r;
        r = $urandom_range(99);
        if (r < 80) return rsdam_pkg::t_byte'(8'h61 + $urandom_range(2));
        if (r < 85) begin
            case ($urandom_range(3))
                0: return rsdam_pkg::CH_DOT;
                1: return rsdam_pkg::CH_STAR;
                2: return rsdam_pkg::CH_CARET;
                default: return rsdam_pkg::CH_DOLLAR;
            endcase
        end
        return rsdam_pkg::t_byte'($urandom);
    endfunction

    initial begin
        logic [63:0]      lo;
        logic [63:0]      hi;
        rsdam_pkg::t_byte pb[16];
        rsdam_pkg::t_byte b;
        int               len;
        int               r;
        int               tlen;
        int               items_sent;
        int               grp;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (cases[c]) begin
            if (cases[c].load) begin
                drain();
                lo = '0;
                hi = '0;
                for (int k = 0; k < cases[c].pat.len(); k++) begin
                    if (k < 8)
                        lo[8*k +: 8] = cases[c].pat[k];
                    else
                        hi[8*(k-8) +: 8] = cases[c].pat[k];
                end
                load_pattern(lo, hi, 5'(cases[c].plen));
            end
            for (int k = 0; k < cases[c].txt.len(); k++) begin
                b = (cases[c].txt[k] == "#") ? 8'h00 : cases[c].txt[k];
                push_item(b, 1'b0, -1);
            end
            if (cases[c].term)
                push_item(rsdam_pkg::t_byte'($urandom), 1'b1, cases[c].want);
        end

        items_sent = 0;
        for (grp = 0; items_sent < RANDOM_ITEMS; grp++) begin
            drain();
            case (grp % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase

            if (grp == 0) begin
                lo  = '1;
                hi  = '1;
                len = 31;
            end else if (grp == 1) begin
                lo  = '0;
                hi  = '0;
                len = 16;
            end else begin
                r = $urandom_range(99);
                if (r < 5)       len = 0;
                else if (r < 15) len = $urandom_range(31, 17);
                else if (r < 30) len = $urandom_range(16, 9);
                else             len = $urandom_range(8, 1);
                foreach (pb[k])
                    pb[k] = (k < len) ? pattern_symbol() : rsdam_pkg::t_byte'($urandom);
                if (len >= 1 && $urandom_range(99) < 30)
                    pb[0] = rsdam_pkg::CH_CARET;
                if (len >= 1 && len <= 16 && $urandom_range(99) < 30)
                    pb[len-1] = rsdam_pkg::CH_DOLLAR;
                foreach (pb[k]) begin
                    if (k < 8)
                        lo[8*k +: 8] = pb[k];
                    else
                        hi[8*(k-8) +: 8] = pb[k];
                end
            end
            load_pattern(lo, hi, 5'(len));

            repeat ($urandom_range(6, 3)) begin
                tlen = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
                for (int k = 0; k < tlen; k++) begin
                    b = (grp == 0) ? rsdam_pkg::t_byte'($urandom) : text_symbol();
                    push_item(b, 1'b0, -1);
                    items_sent++;
                end
                push_item(rsdam_pkg::t_byte'($urandom), 1'b1, -1);
                items_sent++;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
